### rtl/rrcm_pkg.sv
// Package for the row/column mean profile block.
// Holds the result kind codes, register indexes and the divider request type.
package rrcm_pkg;

  localparam int unsigned CfgIdxBits = 3;
  localparam int unsigned CfgBits    = 12;
  localparam int unsigned PosBits    = 11;
  localparam int unsigned MeanBits   = 24;
  localparam int unsigned KindBits   = 2;

  typedef enum logic [KindBits-1:0] {
    KIND_ROW   = 2'd0,
    KIND_COL   = 2'd1,
    KIND_FRAME = 2'd2
  } kind_e;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_LEFT   = 3'd2,
    REG_RIGHT  = 3'd3,
    REG_TOP    = 3'd4,
    REG_BOTTOM = 3'd5
  } reg_e;

  // One mean to compute: the divider sees this alongside the numerator.
  typedef struct packed {
    kind_e              kind;
    logic [PosBits-1:0] position;
    logic               div_zero;
    logic               div_neg;
  } mean_tag_t;

endpackage

### rtl/rrcm_ram.sv
// Generic single-port-write, single-read synchronous RAM, registered read.
// No dependencies.
module rrcm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

### rtl/rrcm_div.sv
// Restoring bit-serial divider producing a saturated fixed-point mean.
// Depends on rrcm_pkg.
module rrcm_div #(
  parameter int unsigned NumBits = 40,
  parameter int unsigned DenBits = 24
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [NumBits-1:0]  num_i,
  input  logic [DenBits-1:0]  den_i,
  input  rrcm_pkg::mean_tag_t tag_i,
  output logic                busy_o,
  output logic                done_o,
  output rrcm_pkg::mean_tag_t tag_o,
  output logic [rrcm_pkg::MeanBits-1:0] mean_o
);
  import rrcm_pkg::*;

  localparam int unsigned CntBits = $clog2(NumBits + 1);

  logic [NumBits-1:0] quo_q, quo_d;
  logic [DenBits:0]   rem_q, rem_d;
  logic [DenBits-1:0] den_q;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic               busy_q, done_q;
  mean_tag_t          tag_q;
  logic [DenBits:0]   trial;

  always_comb begin
    rem_d = {rem_q[DenBits-1:0], quo_q[NumBits-1]};
    quo_d = {quo_q[NumBits-2:0], 1'b0};
    trial = rem_d - {1'b0, den_q};
    if (!trial[DenBits]) begin
      rem_d    = trial;
      quo_d[0] = 1'b1;
    end
    cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= CntBits'(NumBits);
      end else if (busy_q) begin
        cnt_q <= cnt_d;
        if (cnt_d == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
      tag_q <= tag_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign busy_o = busy_q || done_q;
  assign done_o = done_q;
  assign tag_o  = tag_q;

  always_comb begin
    if (tag_q.div_zero) begin
      mean_o = '1;
    end else if (tag_q.div_neg) begin
      mean_o = '0;
    end else if (|quo_q[NumBits-1:MeanBits]) begin
      mean_o = '1;
    end else begin
      mean_o = quo_q[MeanBits-1:0];
    end
  end
endmodule

### rtl/roi_row_column_mean_profile.sv
// Top level of the row/column mean profile block.
// Depends on rrcm_pkg, rrcm_ram and rrcm_div.
//
// Pixels arrive in raster order. Each pixel updates a running row sum, the
// frame sum and its column's entry in a column-sum RAM (read, add, write
// back). A pixel that ends a row, lies in the last row, or ends the frame
// produces up to three means (row, column, frame, in that order); each one
// goes through a bit-serial restoring divider that takes one quotient bit
// per cycle. An item with no mean is accepted with the RAM read, then added
// and written back; a mean also waits on the divider and on the last result
// being taken. Means are floor(sum * 2^FRAC_BITS / divisor) saturated to all
// ones; a zero divisor gives all ones with zero_divisor set, a negative
// one gives zero. The column-sum RAM needs no clearing: row 0 of every
// frame overwrites each entry. Configuration is written through a plain
// write port, by the user only while idle; the block does not check this.
module roi_row_column_mean_profile #(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_HEIGHT = 2048,
  parameter int unsigned PIXEL_BITS = 16,
  parameter int unsigned FRAC_BITS  = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [rrcm_pkg::CfgIdxBits-1:0] cfg_index_i,
  input  logic [rrcm_pkg::CfgBits-1:0]    cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] pixel_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [10:0] position_o,
  output logic [23:0] mean_value_o,
  output logic        zero_divisor_o,
  output logic        frame_done_o
);
  import rrcm_pkg::*;

  localparam int unsigned ColBits   = $clog2(MAX_WIDTH);
  localparam int unsigned RowBits   = $clog2(MAX_HEIGHT);
  localparam int unsigned WCntBits  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HCntBits  = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned ColSumBits = PIXEL_BITS + RowBits;
  localparam int unsigned RowSumBits = PIXEL_BITS + ColBits;
  localparam int unsigned FrmSumBits = PIXEL_BITS + ColBits + RowBits;
  localparam int unsigned NumBits   = FrmSumBits + FRAC_BITS;
  localparam int unsigned DenBits   = WCntBits + HCntBits;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_ROW, ST_COL, ST_FRAME, ST_WAIT
  } state_e;

  // Configuration registers.
  logic [CfgBits-1:0] width_q, height_q;
  logic signed [CfgBits-1:0] left_q, right_q, top_q, bottom_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 12'd640;
      height_q <= 12'd480;
      left_q   <= -12'sd1;
      right_q  <= 12'sd639;
      top_q    <= -12'sd1;
      bottom_q <= 12'sd479;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_WIDTH:  width_q  <= cfg_data_i;
        REG_HEIGHT: height_q <= cfg_data_i;
        REG_LEFT:   left_q   <= cfg_data_i;
        REG_RIGHT:  right_q  <= cfg_data_i;
        REG_TOP:    top_q    <= cfg_data_i;
        REG_BOTTOM: bottom_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp dimensions: zero counts as one, oversize as the maximum.
  logic [WCntBits-1:0] w_eff;
  logic [HCntBits-1:0] h_eff;
  always_comb begin
    if (width_q == '0) w_eff = WCntBits'(1);
    else if (32'(width_q) > MAX_WIDTH) w_eff = WCntBits'(MAX_WIDTH);
    else w_eff = WCntBits'(width_q);
    if (height_q == '0) h_eff = HCntBits'(1);
    else if (32'(height_q) > MAX_HEIGHT) h_eff = HCntBits'(MAX_HEIGHT);
    else h_eff = HCntBits'(height_q);
  end

  state_e state_q;
  logic [ColBits-1:0]    col_q;
  logic [RowBits-1:0]    row_q;
  logic [PIXEL_BITS-1:0] pix_q;
  logic [RowSumBits-1:0] row_sum_q;
  logic [FrmSumBits-1:0] frm_sum_q;
  logic [ColSumBits-1:0] col_base_q;
  logic                  row_end_q, last_row_q;
  logic [PosBits-1:0]    pos_row_q, pos_col_q;

  logic accept;
  assign in_ready_o = (state_q == ST_IDLE);
  assign accept = in_valid_i && in_ready_o;

  // Column-sum RAM: read on accept, write back in ST_READ.
  logic [ColSumBits-1:0] ram_rdata, col_new;
  logic ram_we;
  rrcm_ram #(.Width(ColSumBits), .Depth(MAX_WIDTH)) u_col_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (col_q),
    .wdata_i (col_new),
    .raddr_i (col_q),
    .rdata_o (ram_rdata)
  );

  logic in_col_roi, in_row_roi;
  always_comb begin
    in_col_roi = ($signed({1'b0, col_q}) > left_q) &&
                 ($signed({1'b0, col_q}) <= right_q);
    in_row_roi = ($signed({1'b0, row_q}) > top_q) &&
                 ($signed({1'b0, row_q}) <= bottom_q);
    col_new = (row_q == '0) ? '0 : ram_rdata;
    if (in_row_roi) col_new = col_new + ColSumBits'(pix_q);
  end
  assign ram_we = (state_q == ST_READ);

  // Divider requests: start only once the divider and the output register
  // are both free, so a waiting mean is never overwritten.
  logic div_start, div_busy, div_done, div_go;
  logic [NumBits-1:0] div_num;
  logic [DenBits-1:0] div_den;
  mean_tag_t div_tag, div_tag_out;
  logic [MeanBits-1:0] div_mean;
  logic signed [CfgBits:0] dcol, drow;

  assign dcol = {right_q[CfgBits-1], right_q} - {left_q[CfgBits-1], left_q};
  assign drow = {bottom_q[CfgBits-1], bottom_q} - {top_q[CfgBits-1], top_q};

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    div_tag   = '{kind: KIND_ROW, position: '0, div_zero: 1'b0, div_neg: 1'b0};
    case (state_q)
      ST_ROW: begin
        div_start = div_go;
        div_num = NumBits'(row_sum_q) << FRAC_BITS;
        div_den = DenBits'(dcol[CfgBits-1:0]);
        div_tag = '{kind: KIND_ROW, position: pos_row_q,
                    div_zero: dcol == '0, div_neg: dcol[CfgBits]};
      end
      ST_COL: begin
        div_start = div_go;
        div_num = NumBits'(col_base_q) << FRAC_BITS;
        div_den = DenBits'(drow[CfgBits-1:0]);
        div_tag = '{kind: KIND_COL, position: pos_col_q,
                    div_zero: drow == '0, div_neg: drow[CfgBits]};
      end
      ST_FRAME: begin
        div_start = div_go;
        div_num = NumBits'(frm_sum_q) << FRAC_BITS;
        div_den = DenBits'(w_eff) * DenBits'(h_eff);
        div_tag = '{kind: KIND_FRAME, position: '0,
                    div_zero: 1'b0, div_neg: 1'b0};
      end
      default: ;
    endcase
  end

  rrcm_div #(.NumBits(NumBits), .DenBits(DenBits)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .tag_i   (div_tag),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .tag_o   (div_tag_out),
    .mean_o  (div_mean)
  );

  // Output register.
  logic out_valid_q;
  logic [1:0] kind_q;
  logic [PosBits-1:0] pos_q;
  logic [MeanBits-1:0] mean_q;
  logic zd_q, fd_q;

  assign div_go = !div_busy && !out_valid_q;

  logic row_end_c, last_row_c;
  assign row_end_c  = (WCntBits'(col_q) + 1'b1) >= w_eff;
  assign last_row_c = (HCntBits'(row_q) + 1'b1) >= h_eff;

  // State machine: sequence one pixel, then hold for each mean.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      col_q       <= '0;
      row_q       <= '0;
      row_sum_q   <= '0;
      frm_sum_q   <= '0;
      out_valid_q <= 1'b0;
      row_end_q   <= 1'b0;
      last_row_q  <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (div_done) begin
        out_valid_q <= 1'b1;
        kind_q <= div_tag_out.kind;
        pos_q  <= div_tag_out.position;
        mean_q <= div_mean;
        zd_q   <= div_tag_out.div_zero;
        fd_q   <= (div_tag_out.kind == KIND_FRAME);
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            pix_q   <= PIXEL_BITS'(pixel_i);
            state_q <= ST_READ;
          end
        end
        ST_READ: begin
          // Add into row/frame sums, write back the column, advance counters.
          col_base_q <= col_new;
          frm_sum_q  <= frm_sum_q + FrmSumBits'(pix_q);
          if (in_col_roi) row_sum_q <= row_sum_q + RowSumBits'(pix_q);
          row_end_q  <= row_end_c;
          last_row_q <= last_row_c;
          pos_row_q  <= PosBits'(row_q);
          pos_col_q  <= PosBits'(col_q);
          if (row_end_c) begin
            col_q <= '0;
            row_q <= last_row_c ? '0 : row_q + 1'b1;
          end else begin
            col_q <= col_q + 1'b1;
          end
          if (row_end_c) state_q <= ST_ROW;
          else if (last_row_c) state_q <= ST_COL;
          else state_q <= ST_IDLE;
        end
        ST_ROW, ST_COL, ST_FRAME: begin
          if (div_go) begin
            if (state_q == ST_ROW) row_sum_q <= '0;
            if (state_q == ST_FRAME) frm_sum_q <= '0;
            state_q <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          // Move on once the mean has been handed to the output register.
          if (div_done) begin
            if (div_tag_out.kind == KIND_ROW && last_row_q) state_q <= ST_COL;
            else if (div_tag_out.kind == KIND_COL && row_end_q) state_q <= ST_FRAME;
            else state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = kind_q;
  assign position_o     = pos_q;
  assign mean_value_o   = mean_q;
  assign zero_divisor_o = zd_q;
  assign frame_done_o   = fd_q;
endmodule

### rtl/rrcm_checker.sv
// Port-level checker for the row/column mean profile block.
// Depends on rrcm_pkg; bound to roi_row_column_mean_profile.
module rrcm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  kind_o,
  input logic [10:0] position_o,
  input logic [23:0] mean_value_o,
  input logic        zero_divisor_o,
  input logic        frame_done_o
);
  import rrcm_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(mean_value_o))
    else $error("result dropped while stalled");

  a_done_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (frame_done_o == (kind_o == KIND_FRAME)))
    else $error("frame_done does not match frame kind");

  a_frame_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_done_o |-> position_o == '0 && !zero_divisor_o)
    else $error("frame mean with bad position or flag");

  a_zd_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_divisor_o |-> mean_value_o == 24'hFFFFFF)
    else $error("zero divisor without saturation");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second item accepted while first in flight");
endmodule

bind roi_row_column_mean_profile rrcm_checker u_rrcm_checker (.*);
